@@ rtl/fep_pkg.sv @@
package fep_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_SYNC_BYTE   = 3'd0;
    localparam logic [2:0] CFG_MAX_LENGTH  = 3'd1;
    localparam logic [2:0] CFG_CB_THRESH   = 3'd2;
    localparam logic [2:0] CFG_NO_EVENT    = 3'd3;
    localparam logic [2:0] CFG_SHORT_LEN   = 3'd4;
    localparam logic [2:0] CFG_LONG_LEN    = 3'd5;

    localparam logic [7:0] RST_SYNC_BYTE   = 8'd165;
    localparam logic [7:0] RST_MAX_LENGTH  = 8'd13;
    localparam logic [7:0] RST_CB_THRESH   = 8'd32;
    localparam logic [7:0] RST_NO_EVENT    = 8'd0;
    localparam logic [3:0] RST_SHORT_LEN   = 4'd4;
    localparam logic [3:0] RST_LONG_LEN    = 4'd10;

    // payload count width, holds counts up to 31
    localparam int CNT_W = 5;

    typedef struct packed {
        logic [7:0] sync_byte;
        logic [7:0] max_length;
        logic [7:0] cb_thresh;
        logic [7:0] no_event;
        logic [3:0] short_len;
        logic [3:0] long_len;
    } t_cfg;

    // front to back: payload writes and end-of-message verdict
    typedef struct packed {
        logic             wr_en;
        logic [7:0]       wr_data;
        logic             commit;
        logic             rollback;
        logic [7:0]       ev_type;
        logic [CNT_W-1:0] count;
    } t_f2b;

    typedef struct packed {
        logic [7:0] ev_type;
        logic [3:0] index;
        logic [7:0] data;
        logic       last;
    } t_res;

endpackage

@@ rtl/fep_front.sv @@
module fep_front #(
    parameter int MAX_PAYLOAD = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fep_pkg::t_cfg i_cfg,
    input  logic          i_acc,
    input  logic [7:0]    i_byte,
    output fep_pkg::t_f2b o_f2b
);

    localparam int CW = fep_pkg::CNT_W;

    typedef enum logic [1:0] {
        PH_LENGTH,
        PH_TYPE,
        PH_PAYLOAD,
        PH_TRAILER
    } t_phase;

    t_phase         r_phase, n_phase;
    logic           r_oos, n_oos;
    logic [7:0]     r_ptype, n_ptype;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [CW-1:0]  size;
    logic [CW-1:0]  raw;
    logic           trl;
    fep_pkg::t_f2b  f2b;

    // payload size, re-evaluated on every byte
    always_comb begin
        raw = (r_ptype < i_cfg.cb_thresh) ? CW'(i_cfg.short_len) : CW'(i_cfg.long_len);
        if (raw == '0) begin
            raw = CW'(1);
        end
        if (raw > CW'(MAX_PAYLOAD)) begin
            raw = CW'(MAX_PAYLOAD);
        end
        size = raw;
    end

    always_comb begin
        n_phase = r_phase;
        n_oos   = r_oos;
        n_ptype = r_ptype;
        n_cnt   = r_cnt;
        trl     = 1'b0;
        f2b     = '0;
        f2b.wr_data = i_byte;
        f2b.ev_type = r_ptype;
        f2b.count   = r_cnt;
        if (i_acc) begin
            if (r_oos) begin
                if (i_byte == i_cfg.sync_byte) begin
                    n_oos   = 1'b0;
                    n_ptype = i_cfg.no_event;
                    n_cnt   = '0;
                    n_phase = PH_LENGTH;
                end
            end else begin
                case (r_phase)
                    PH_LENGTH: begin
                        if (i_byte > i_cfg.max_length) begin
                            n_oos = 1'b1;
                        end else begin
                            n_phase = PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        n_ptype = i_byte;
                        n_cnt   = '0;
                        n_phase = (i_byte == i_cfg.no_event) ? PH_LENGTH : PH_PAYLOAD;
                    end
                    PH_PAYLOAD: begin
                        if (r_cnt >= size) begin
                            trl = 1'b1;
                        end else begin
                            f2b.wr_en = 1'b1;
                            n_cnt     = r_cnt + CW'(1);
                            if (r_cnt + CW'(1) >= size) begin
                                n_phase = PH_TRAILER;
                            end
                        end
                    end
                    default: begin
                        trl = 1'b1;
                    end
                endcase
                if (trl) begin
                    n_phase = PH_LENGTH;
                    n_cnt   = '0;
                    if (i_byte != i_cfg.sync_byte) begin
                        n_oos        = 1'b1;
                        f2b.rollback = 1'b1;
                    end else begin
                        f2b.commit = 1'b1;
                        n_ptype    = i_cfg.no_event;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LENGTH;
            r_oos   <= 1'b0;
            r_ptype <= fep_pkg::RST_NO_EVENT;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_oos   <= n_oos;
            r_ptype <= n_ptype;
            r_cnt   <= n_cnt;
        end
    end

    assign o_f2b = f2b;

endmodule

@@ rtl/fep_back.sv @@
module fep_back #(
    parameter int MAX_PAYLOAD = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fep_pkg::t_f2b i_f2b,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output fep_pkg::t_res o_res
);

    localparam int CW    = fep_pkg::CNT_W;
    localparam int AW    = $clog2(MAX_PAYLOAD) + 1;   // ring holds at least two full-size payloads
    localparam int DEPTH = 2 ** AW;
    localparam int QAW   = 2;
    localparam int QD    = 2 ** QAW;

    // payload ring: tentative write, committed and read pointers
    logic [7:0]    r_mem [DEPTH];
    logic [AW:0]   r_wr_ptr, r_cm_ptr, r_rd_ptr;

    // descriptor queue of committed messages
    logic [7:0]    r_dq_type [QD];
    logic [CW-1:0] r_dq_cnt  [QD];
    logic [QAW:0]  r_dq_wp, r_dq_rp;
    logic [QAW:0]  dq_cnt;

    // run being read out
    logic          r_busy;
    logic [7:0]    r_cur_type;
    logic [CW-1:0] r_cur_cnt, r_idx;

    // read stage
    logic          r_s1_vld;
    logic [7:0]    r_s1_type, r_s1_data;
    logic [3:0]    r_s1_idx;
    logic          r_s1_last;

    // result queue
    fep_pkg::t_res r_oq [QD];
    logic [QAW:0]  r_oq_wp, r_oq_rp;
    logic [QAW:0]  oq_cnt;

    logic          issue;
    logic          is_last;
    logic          load;
    logic          pop_ok;

    assign dq_cnt  = r_dq_wp - r_dq_rp;
    assign oq_cnt  = r_oq_wp - r_oq_rp;
    assign issue   = r_busy && ((oq_cnt + (QAW+1)'(r_s1_vld)) < (QAW+1)'(QD));
    assign is_last = (r_idx + CW'(1)) == r_cur_cnt;
    assign load    = !r_busy && (dq_cnt != '0);
    assign pop_ok  = i_pop && !o_empty;

    assign o_full  = ((r_wr_ptr - r_rd_ptr) == (AW+1)'(DEPTH)) || (dq_cnt == (QAW+1)'(QD));
    assign o_empty = (oq_cnt == '0);
    assign o_res   = r_oq[r_oq_rp[QAW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_f2b.wr_en) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_f2b.wr_data;
        end
        if (issue) begin
            r_s1_data <= r_mem[r_rd_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_f2b.commit) begin
            r_dq_type[r_dq_wp[QAW-1:0]] <= i_f2b.ev_type;
            r_dq_cnt[r_dq_wp[QAW-1:0]]  <= i_f2b.count;
        end
        if (load) begin
            r_cur_type <= r_dq_type[r_dq_rp[QAW-1:0]];
            r_cur_cnt  <= r_dq_cnt[r_dq_rp[QAW-1:0]];
        end
        if (issue) begin
            r_s1_type <= r_cur_type;
            r_s1_idx  <= 4'(r_idx);
            r_s1_last <= is_last;
        end
        if (r_s1_vld) begin
            r_oq[r_oq_wp[QAW-1:0]] <= '{ev_type: r_s1_type, index: r_s1_idx,
                                        data: r_s1_data, last: r_s1_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_cm_ptr <= '0;
            r_rd_ptr <= '0;
            r_dq_wp  <= '0;
            r_dq_rp  <= '0;
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_s1_vld <= 1'b0;
            r_oq_wp  <= '0;
            r_oq_rp  <= '0;
        end else begin
            if (i_f2b.wr_en) begin
                r_wr_ptr <= r_wr_ptr + (AW+1)'(1);
            end else if (i_f2b.rollback) begin
                r_wr_ptr <= r_cm_ptr;
            end
            if (i_f2b.commit) begin
                r_cm_ptr <= r_wr_ptr;
                r_dq_wp  <= r_dq_wp + (QAW+1)'(1);
            end
            if (load) begin
                r_busy  <= 1'b1;
                r_idx   <= '0;
                r_dq_rp <= r_dq_rp + (QAW+1)'(1);
            end else if (issue) begin
                r_rd_ptr <= r_rd_ptr + (AW+1)'(1);
                r_idx    <= r_idx + CW'(1);
                if (is_last) begin
                    r_busy <= 1'b0;
                end
            end
            r_s1_vld <= issue;
            if (r_s1_vld) begin
                r_oq_wp <= r_oq_wp + (QAW+1)'(1);
            end
            if (pop_ok) begin
                r_oq_rp <= r_oq_rp + (QAW+1)'(1);
            end
        end
    end

    a_ring_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) <= (AW+1)'(DEPTH))
        else $error("payload ring overrun");

    a_commit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cm_ptr - r_rd_ptr) <= (r_wr_ptr - r_rd_ptr))
        else $error("committed pointer outside ring window");

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (oq_cnt + (QAW+1)'(r_s1_vld)) <= (QAW+1)'(QD))
        else $error("result queue overrun");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && is_last) |=> !r_busy)
        else $error("run did not end on last word");

endmodule

@@ rtl/framed_event_message_parser_top.sv @@
// Framed event message parser.
// Input channel: one received byte per word on i_rx_byte, taken when push is
// high and full is low. Messages are: length, event type, payload, trailer;
// a no-event type ends a message after its type byte. Result channel: one
// payload byte per word (o_event_type, o_byte_index, o_payload_byte,
// o_last) shown while empty is low, taken when pop is high. A message's run
// appears only once its trailer matches the sync byte. Throughput: one input
// word per cycle while full is low; results leave at one word per cycle
// while the receiver pops, pausing between runs while the next descriptor
// loads. A committed run passes the run load, ring read and result queue.
// Configuration: i_cfg_we / i_cfg_idx / i_cfg_data write one register per
// cycle; indexes beyond the list are ignored.
// Reset (synchronous, i_rst_n low) loads register defaults, puts the parser
// in sync awaiting a length byte and empties all queues.
// When the receiver stalls, the result queue and the payload ring fill; full
// rises once the payload ring is full (32 bytes at the default size, at least
// two full-size payloads) or four messages wait, and no input byte is lost.
module framed_event_message_parser_top #(
    parameter int MAX_PAYLOAD = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_event_type,
    output logic [3:0] o_byte_index,
    output logic [7:0] o_payload_byte,
    output logic       o_last,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    fep_pkg::t_cfg r_cfg;
    fep_pkg::t_f2b f2b;
    fep_pkg::t_res res;
    logic          acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_byte  <= fep_pkg::RST_SYNC_BYTE;
            r_cfg.max_length <= fep_pkg::RST_MAX_LENGTH;
            r_cfg.cb_thresh  <= fep_pkg::RST_CB_THRESH;
            r_cfg.no_event   <= fep_pkg::RST_NO_EVENT;
            r_cfg.short_len  <= fep_pkg::RST_SHORT_LEN;
            r_cfg.long_len   <= fep_pkg::RST_LONG_LEN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fep_pkg::CFG_SYNC_BYTE:  r_cfg.sync_byte  <= i_cfg_data;
                fep_pkg::CFG_MAX_LENGTH: r_cfg.max_length <= i_cfg_data;
                fep_pkg::CFG_CB_THRESH:  r_cfg.cb_thresh  <= i_cfg_data;
                fep_pkg::CFG_NO_EVENT:   r_cfg.no_event   <= i_cfg_data;
                fep_pkg::CFG_SHORT_LEN:  r_cfg.short_len  <= i_cfg_data[3:0];
                fep_pkg::CFG_LONG_LEN:   r_cfg.long_len   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign acc = push && !full;

    fep_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_acc   (acc),
        .i_byte  (i_rx_byte),
        .o_f2b   (f2b)
    );

    fep_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_f2b   (f2b),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (res)
    );

    assign o_event_type   = res.ev_type;
    assign o_byte_index   = res.index;
    assign o_payload_byte = res.data;
    assign o_last         = res.last;

endmodule
